>>> design/zrf_pkg.sv
package zrf_pkg;

    // offset counters saturate at all ones of this width
    localparam int OFFSET_WIDTH = 32;
    localparam int IDX_W        = 33;
    localparam int TOT_W        = IDX_W + 1;
    localparam int HDR_W        = 18;
    localparam int OUT_W        = 32;
    localparam int MAX_RES      = 3;
    localparam int CNT_W        = 2;
    localparam int TDATA_W      = 88;

    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = {OFFSET_WIDTH{1'b1}};
    localparam logic [IDX_W-1:0]        IDX_MAX = {IDX_W{1'b1}};

    localparam logic [31:0] SIG_LOCAL  = 32'h0403_4b50;
    localparam logic [31:0] SIG_DIRHDR = 32'h0201_4b50;
    localparam logic [31:0] SIG_END    = 32'h0605_4b50;

    localparam logic [IDX_W-1:0] SIG_LAST_IDX = IDX_W'(3);

    // local file header layout
    localparam logic [IDX_W-1:0] LOC_CSIZE0   = IDX_W'('h12);
    localparam logic [IDX_W-1:0] LOC_CSIZE1   = IDX_W'('h13);
    localparam logic [IDX_W-1:0] LOC_CSIZE2   = IDX_W'('h14);
    localparam logic [IDX_W-1:0] LOC_CSIZE3   = IDX_W'('h15);
    localparam logic [IDX_W-1:0] LOC_NAME_LO  = IDX_W'('h1a);
    localparam logic [IDX_W-1:0] LOC_NAME_HI  = IDX_W'('h1b);
    localparam logic [IDX_W-1:0] LOC_EXTRA_LO = IDX_W'('h1c);
    localparam logic [IDX_W-1:0] LOC_EXTRA_HI = IDX_W'('h1d);
    localparam logic [HDR_W-1:0] LOC_FIXED    = HDR_W'('h1e);

    // central directory file header layout
    localparam logic [IDX_W-1:0] DIR_NAME_LO  = IDX_W'('h1c);
    localparam logic [IDX_W-1:0] DIR_NAME_HI  = IDX_W'('h1d);
    localparam logic [IDX_W-1:0] DIR_EXTRA_LO = IDX_W'('h1e);
    localparam logic [IDX_W-1:0] DIR_EXTRA_HI = IDX_W'('h1f);
    localparam logic [IDX_W-1:0] DIR_CMT_LO   = IDX_W'('h20);
    localparam logic [IDX_W-1:0] DIR_CMT_HI   = IDX_W'('h21);
    localparam logic [IDX_W-1:0] DIR_DONE_MIN = IDX_W'('h2d);
    localparam logic [HDR_W-1:0] DIR_FIXED    = HDR_W'('h2e);

    // end of central directory layout
    localparam logic [IDX_W-1:0] END_CMT_LO   = IDX_W'('h14);
    localparam logic [IDX_W-1:0] END_CMT_HI   = IDX_W'('h15);
    localparam logic [HDR_W-1:0] END_FIXED    = HDR_W'('h16);

    typedef enum logic [4:0] {
        PH_SIG    = 5'b00001,
        PH_LOCAL  = 5'b00010,
        PH_DIRHDR = 5'b00100,
        PH_END    = 5'b01000,
        PH_STOP   = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        KIND_LOCAL  = 3'd0,
        KIND_DIRHDR = 3'd1,
        KIND_END    = 3'd2,
        KIND_SPAN   = 3'd3,
        KIND_STOP   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [OUT_W-1:0] offset;
        logic [HDR_W-1:0] hdr_len;
        logic [OUT_W-1:0] body_len;
        logic             last;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]          cnt;
        t_result [MAX_RES-1:0]     res;
    } t_bundle;

    function automatic logic [OFFSET_WIDTH-1:0] sat_off(input logic [OFFSET_WIDTH-1:0] v);
        return (v == OFF_MAX) ? v : v + OFFSET_WIDTH'(1);
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic [OFFSET_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[OUT_W-1:0];
    endfunction

    function automatic t_result make_res(input t_kind k, input logic [OFFSET_WIDTH-1:0] off,
                                         input logic [HDR_W-1:0] hdr,
                                         input logic [OUT_W-1:0] body);
        t_result r;
        r.kind     = k;
        r.offset   = to_out(off);
        r.hdr_len  = hdr;
        r.body_len = body;
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

>>> design/zrf_parser.sv
module zrf_parser
    import zrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [7:0] i_byte,
    input  logic       i_eof,
    output t_bundle    o_bundle
);

    t_phase                  r_phase, n_phase;
    logic [OFFSET_WIDTH-1:0] r_stream_off, n_stream_off;
    logic [OFFSET_WIDTH-1:0] r_rec_start, n_rec_start;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [31:0]             r_sig, n_sig;
    logic [15:0]             r_name, n_name;
    logic [15:0]             r_extra, n_extra;
    logic [15:0]             r_comment, n_comment;
    logic [31:0]             r_csize, n_csize;
    logic                    r_in_dir, n_in_dir;
    logic [OFFSET_WIDTH-1:0] r_dir_start, n_dir_start;

    logic [IDX_W-1:0]        idx_inc;
    logic [TOT_W-1:0]        idx_next;
    logic [HDR_W-1:0]        hdr_len;
    logic [TOT_W-1:0]        tot_len;
    logic                    done;
    logic [CNT_W-1:0]        v_cnt;
    t_result [MAX_RES-1:0]   v_res;

    assign idx_inc  = (r_idx == IDX_MAX) ? r_idx : r_idx + IDX_W'(1);
    assign idx_next = TOT_W'(r_idx) + TOT_W'(1);

    always_comb begin
        n_phase      = r_phase;
        n_stream_off = sat_off(r_stream_off);
        n_rec_start  = r_rec_start;
        n_idx        = r_idx;
        n_sig        = r_sig;
        n_name       = r_name;
        n_extra      = r_extra;
        n_comment    = r_comment;
        n_csize      = r_csize;
        n_in_dir     = r_in_dir;
        n_dir_start  = r_dir_start;
        hdr_len      = '0;
        tot_len      = '0;
        done         = 1'b0;
        v_cnt        = '0;
        v_res        = '0;

        unique case (r_phase)
            PH_SIG: begin
                n_sig = {i_byte, r_sig[31:8]};
                n_idx = idx_inc;
                if (r_idx >= SIG_LAST_IDX) begin
                    if (n_sig == SIG_LOCAL) begin
                        if (r_in_dir) begin
                            v_res[v_cnt] = make_res(KIND_SPAN, r_dir_start, '0,
                                                    to_out(r_rec_start - r_dir_start));
                            v_cnt = v_cnt + CNT_W'(1);
                            n_in_dir = 1'b0;
                        end
                        n_phase = PH_LOCAL;
                    end else if (n_sig == SIG_DIRHDR || n_sig == SIG_END) begin
                        if (!r_in_dir) begin
                            n_in_dir    = 1'b1;
                            n_dir_start = r_rec_start;
                        end
                        n_phase = (n_sig == SIG_DIRHDR) ? PH_DIRHDR : PH_END;
                    end else begin
                        if (r_in_dir) begin
                            v_res[v_cnt] = make_res(KIND_SPAN, r_dir_start, '0,
                                                    to_out(r_rec_start - r_dir_start));
                            v_cnt = v_cnt + CNT_W'(1);
                            n_in_dir = 1'b0;
                        end
                        v_res[v_cnt] = make_res(KIND_STOP, r_rec_start, '0, to_out(r_rec_start));
                        v_cnt   = v_cnt + CNT_W'(1);
                        n_phase = PH_STOP;
                    end
                end
            end
            PH_LOCAL: begin
                if (r_idx == LOC_CSIZE0) n_csize = {24'b0, i_byte};
                if (r_idx == LOC_CSIZE1) n_csize[15:8]  = i_byte;
                if (r_idx == LOC_CSIZE2) n_csize[23:16] = i_byte;
                if (r_idx == LOC_CSIZE3) n_csize[31:24] = i_byte;
                if (r_idx == LOC_NAME_LO)  n_name  = {8'b0, i_byte};
                if (r_idx == LOC_NAME_HI)  n_name[15:8]  = i_byte;
                if (r_idx == LOC_EXTRA_LO) n_extra = {8'b0, i_byte};
                if (r_idx == LOC_EXTRA_HI) n_extra[15:8] = i_byte;
                hdr_len = LOC_FIXED + HDR_W'(n_name) + HDR_W'(n_extra);
                tot_len = TOT_W'(hdr_len) + TOT_W'(n_csize);
                if (r_idx >= LOC_EXTRA_HI && idx_next == tot_len) begin
                    v_res[v_cnt] = make_res(KIND_LOCAL, r_rec_start, hdr_len, n_csize);
                    v_cnt = v_cnt + CNT_W'(1);
                    done  = 1'b1;
                end
                n_idx = idx_inc;
            end
            PH_DIRHDR: begin
                if (r_idx == DIR_NAME_LO)  n_name    = {8'b0, i_byte};
                if (r_idx == DIR_NAME_HI)  n_name[15:8]    = i_byte;
                if (r_idx == DIR_EXTRA_LO) n_extra   = {8'b0, i_byte};
                if (r_idx == DIR_EXTRA_HI) n_extra[15:8]   = i_byte;
                if (r_idx == DIR_CMT_LO)   n_comment = {8'b0, i_byte};
                if (r_idx == DIR_CMT_HI)   n_comment[15:8] = i_byte;
                hdr_len = DIR_FIXED + HDR_W'(n_name) + HDR_W'(n_extra) + HDR_W'(n_comment);
                if (r_idx >= DIR_DONE_MIN && idx_next == TOT_W'(hdr_len)) begin
                    v_res[v_cnt] = make_res(KIND_DIRHDR, r_rec_start, hdr_len, '0);
                    v_cnt = v_cnt + CNT_W'(1);
                    done  = 1'b1;
                end
                n_idx = idx_inc;
            end
            PH_END: begin
                if (r_idx == END_CMT_LO) n_comment = {8'b0, i_byte};
                if (r_idx == END_CMT_HI) n_comment[15:8] = i_byte;
                hdr_len = END_FIXED + HDR_W'(n_comment);
                if (r_idx >= END_CMT_HI && idx_next == TOT_W'(hdr_len)) begin
                    v_res[v_cnt] = make_res(KIND_END, r_rec_start, hdr_len, '0);
                    v_cnt = v_cnt + CNT_W'(1);
                    done  = 1'b1;
                end
                n_idx = idx_inc;
            end
            PH_STOP: begin
                n_idx = r_idx;
            end
            default: begin
                n_phase = PH_SIG;
            end
        endcase

        // record finished: next byte starts a signature
        if (done) begin
            n_phase     = PH_SIG;
            n_idx       = '0;
            n_rec_start = sat_off(r_stream_off);
        end

        if (i_eof) begin
            if (n_phase != PH_STOP) begin
                if (n_in_dir) begin
                    v_res[v_cnt] = make_res(KIND_SPAN, n_dir_start, '0,
                                            to_out(n_rec_start - n_dir_start));
                    v_cnt = v_cnt + CNT_W'(1);
                end
                v_res[v_cnt] = make_res(KIND_STOP, n_rec_start, '0, to_out(n_rec_start));
                v_cnt = v_cnt + CNT_W'(1);
            end
            n_phase      = PH_SIG;
            n_stream_off = '0;
            n_rec_start  = '0;
            n_idx        = '0;
            n_sig        = '0;
            n_name       = '0;
            n_extra      = '0;
            n_comment    = '0;
            n_csize      = '0;
            n_in_dir     = 1'b0;
            n_dir_start  = '0;
        end

        if (v_cnt != '0) v_res[v_cnt - CNT_W'(1)].last = 1'b1;
    end

    assign o_bundle.cnt = v_cnt;
    assign o_bundle.res = v_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SIG;
            r_stream_off <= '0;
            r_rec_start  <= '0;
            r_idx        <= '0;
            r_sig        <= '0;
            r_name       <= '0;
            r_extra      <= '0;
            r_comment    <= '0;
            r_csize      <= '0;
            r_in_dir     <= 1'b0;
            r_dir_start  <= '0;
        end else if (i_advance) begin
            r_phase      <= n_phase;
            r_stream_off <= n_stream_off;
            r_rec_start  <= n_rec_start;
            r_idx        <= n_idx;
            r_sig        <= n_sig;
            r_name       <= n_name;
            r_extra      <= n_extra;
            r_comment    <= n_comment;
            r_csize      <= n_csize;
            r_in_dir     <= n_in_dir;
            r_dir_start  <= n_dir_start;
        end
    end

endmodule

>>> design/zrf_out_queue.sv
module zrf_out_queue
    import zrf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_bundle i_bundle,
    input  logic    i_ready,
    output logic    o_take,
    output logic    o_valid,
    output t_result o_head
);

    logic [CNT_W-1:0]      r_cnt;
    t_result [MAX_RES-1:0] r_res;
    logic                  pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    // free when empty or once the last held result leaves this cycle
    assign o_take  = (r_cnt == '0) || (r_cnt == CNT_W'(1) && i_ready);
    assign o_head  = r_res[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load && o_take) begin
            r_cnt <= i_bundle.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_take) begin
            r_res <= i_bundle.res;
        end else if (pop) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

endmodule

>>> design/zip_record_framer.sv
// zip record framer
// frames a zip archive arriving one byte per beat on the s_axis side and
// reports each local header, central directory header and end record
// on the m_axis side, plus a beat when a central directory span closes and
// a stop beat when an unknown signature appears or the archive ends
// s_axis: tdata = archive byte, tlast = final byte of the archive
// m_axis: one beat per result, kind on tuser; tlast ends the results of one byte
// a byte is taken into the input register, parsed from there into the result
// register, and its result beats are shown from the result register
// throughput: one byte per cycle while m_axis_tready is high and each byte
// gives at most one result; a byte that gives more stalls the intake while
// the result register drains one beat per cycle (at most three results per
// byte)
// reset (i_rst_n low at a clock edge) empties both registers and puts the
// parser back to waiting for a signature at offset zero; a beat with tlast
// resets the parser alike after its results are formed
// when m_axis_tready is low, results hold and s_axis_tready drops once the
// input register is full while results wait, so no beat is lost
module zip_record_framer
    import zrf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
    input  logic               s_axis_tlast,   // end_of_file
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [31:0] record_offset, [49:32] header_length,
                                               // [81:50] body_length
    output logic [2:0]         m_axis_tuser,   // [2:0] record_kind
    output logic               m_axis_tlast    // last_of_run
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eof;

    logic       take;
    logic       advance;
    t_bundle    bundle;
    t_result    head;

    assign advance       = r_in_valid && take;
    assign s_axis_tready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eof  <= s_axis_tlast;
        end
    end

    // signature match, field capture and record end detection
    zrf_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .i_eof     (r_in_eof),
        .o_bundle  (bundle)
    );

    // result register, up to three results of one byte, one beat a cycle while m_axis_tready is high
    zrf_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_bundle (bundle),
        .i_ready  (m_axis_tready),
        .o_take   (take),
        .o_valid  (m_axis_tvalid),
        .o_head   (head)
    );

    assign m_axis_tdata = {6'b000000, head.body_len, head.hdr_len, head.offset};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

    // a byte that yields results shows a beat in the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && bundle.cnt != '0) |=> m_axis_tvalid)
        else $error("loaded results not presented");

    // the last result formed for a byte carries the run end mark
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bundle.cnt != '0) |-> bundle.res[bundle.cnt - CNT_W'(1)].last)
        else $error("run end mark missing");

    // a result taken without the run end mark is followed by another beat
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("run cut short");

endmodule
